// ----- design/sts_pkg.sv -----
// shared types, constants and codes for the staircase throttle sequencer
// no dependencies
`default_nettype none
package sts_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int PW_W          = 12;
  localparam int PCT_W         = 7;
  localparam int STEP_W        = 7;
  localparam int DWELL_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // divider operand widths: |numerator| < 80 * 4096, denominator <= 4095
  localparam int DIV_NUM_W     = 19;
  localparam int DIV_DEN_W     = 12;

  // divide by 80 as a shift by 4 and a reciprocal multiply by 1/5, exact below 2^16
  localparam int                   PCT_TOP_SH = 4;
  localparam int                   DIV5_SH    = 18;
  localparam int                   DIV5_MUL_W = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL  = 16'hCCCD;
  localparam int                   GOAL_SH_W  = DIV_NUM_W - PCT_TOP_SH;
  localparam int                   GOAL_RCP_W = GOAL_SH_W + DIV5_MUL_W;

  localparam logic [PCT_W-1:0] PCT_TOP   = 7'd80;
  localparam logic [3:0]       RAMP_STEP = 4'd5;
  localparam logic [3:0]       SNAP_BAND = 4'd4;

  localparam logic [PW_W-1:0]    PWM_MIN_RST = 12'd1000;
  localparam logic [PW_W-1:0]    PWM_MAX_RST = 12'd2000;
  localparam logic [STEP_W-1:0]  STEP_RST    = 7'd5;
  localparam logic [DWELL_W-1:0] DWELL_RST   = 16'd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL   = 2'd3;

  localparam logic OP_EVAL   = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_COMPUTE = 3'd1,
    PH_RAMP    = 3'd2,
    PH_DWELL   = 3'd3,
    PH_STOPPED = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_GOAL_MUL,
    S_GOAL_WR,
    S_THR_START,
    S_THR_WAIT,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic             operation;
    logic [NOW_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PW_W-1:0]  pulse_width_us;
    logic [PCT_W-1:0] throttle_percent;
    logic [PCT_W-1:0] setpoint_percent;
    logic             active;
    logic [2:0]       phase;
    logic             pulse_write;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic update;
    logic goal_mul;
    logic div_start;
    logic goal_wr;
    logic thr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic goal_pend;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- design/sts_div.sv -----
// radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on sts_pkg
`default_nettype none
module sts_div #(
  parameter int NUM_W = sts_pkg::DIV_NUM_W,
  parameter int DEN_W = sts_pkg::DIV_DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  import sts_pkg::*;

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    fits     = (shifted >= {1'b0, den_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- design/sts_ctrl.sv -----
// controller state machine: sequences update, setpoint map, divide and result beat
// depends on sts_pkg
`default_nettype none
module sts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sts_pkg::status_t status,
  output sts_pkg::cmd_t         cmd
);
  import sts_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.goal_pend ? S_GOAL_MUL : S_THR_START;
      end
      S_GOAL_MUL: begin
        cmd.goal_mul = 1'b1;
        state_nxt    = S_GOAL_WR;
      end
      S_GOAL_WR: begin
        cmd.goal_wr = 1'b1;
        state_nxt   = S_THR_START;
      end
      S_THR_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_THR_WAIT;
      end
      S_THR_WAIT: begin
        if (status.div_done) begin
          cmd.thr_wr = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/sts_dp.sv -----
// datapath: configuration, sequencer state, pulse ramp, mapping and result register
// depends on sts_pkg and sts_div
`default_nettype none
module sts_dp #(
  parameter int TIME_BITS = sts_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sts_pkg::in_item_t               in_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sts_pkg::out_item_t                   out_data,
  input  wire sts_pkg::cmd_t                   cmd,
  output sts_pkg::status_t                     status
);
  import sts_pkg::*;

  // configuration
  logic [PW_W-1:0]    min_r, max_r;
  logic [STEP_W-1:0]  step_r;
  logic [DWELL_W-1:0] dwell_r;

  // item
  logic                 op_r;
  logic [TIME_BITS-1:0] now_r;

  // sequencer state
  phase_t               phase_r, phase_nxt;
  logic                 running_r, running_nxt;
  logic                 asc_r, asc_nxt;
  logic [PCT_W-1:0]     target_r, target_nxt;
  logic [PW_W-1:0]      pulse_r, pulse_nxt;
  logic [PW_W-1:0]      goal_r, goal_nxt;
  logic [TIME_BITS-1:0] ramp_r, ramp_nxt;
  logic [TIME_BITS-1:0] dstamp_r, dstamp_nxt;
  logic                 wrote_r, wrote_nxt;
  logic [PCT_W-1:0]     thr_r, thr_nxt;
  logic                 goal_pend;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // update step
  phase_t                ph;
  logic [PCT_W:0]        sum;
  logic signed [PW_W+1:0] ramp_diff;
  logic signed [PW_W+1:0] ramp_pw;
  logic [PW_W+1:0]       ramp_mag;
  logic [TIME_BITS-1:0]  elapsed;

  // mapping and divider operands
  logic signed [PW_W:0] rng;
  logic [PW_W-1:0]      rng_abs;
  logic signed [PW_W:0] pdiff;
  logic [PW_W-1:0]      pdiff_abs;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 div_done;
  logic signed [PW_W+1:0] goal_val;
  logic [DIV_NUM_W-1:0] goal_prod;
  logic [DIV_NUM_W-1:0] goal_prod_r;
  logic [GOAL_SH_W-1:0] goal_sh;
  logic [GOAL_RCP_W-1:0] goal_recip;
  logic [PW_W-1:0]      goal_quo;
  logic [DIV_NUM_W-1:0] thr_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= PWM_MIN_RST;
      max_r   <= PWM_MAX_RST;
      step_r  <= STEP_RST;
      dwell_r <= DWELL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PWM_MIN: min_r   <= cfg_data[PW_W-1:0];
        CFG_PWM_MAX: max_r   <= cfg_data[PW_W-1:0];
        CFG_STEP:    step_r  <= cfg_data[STEP_W-1:0];
        CFG_DWELL:   dwell_r <= cfg_data[DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.operation;
      now_r <= TIME_BITS'(in_data.now_ms);
    end
  end

  always_comb begin
    ph          = running_r ? phase_r : PH_STOPPED;
    phase_nxt   = phase_r;
    running_nxt = running_r;
    asc_nxt     = asc_r;
    target_nxt  = target_r;
    pulse_nxt   = pulse_r;
    ramp_nxt    = ramp_r;
    dstamp_nxt  = dstamp_r;
    wrote_nxt   = 1'b0;
    goal_pend   = 1'b0;
    sum         = {1'b0, target_r} + {1'b0, step_r};
    ramp_diff   = $signed({2'b00, goal_r}) - $signed({2'b00, pulse_r});
    ramp_mag    = ramp_diff[PW_W+1] ? (PW_W+2)'(-ramp_diff) : ramp_diff;
    ramp_pw     = ramp_diff[PW_W+1] ?
                  $signed({2'b00, pulse_r}) - $signed({{(PW_W-2){1'b0}}, RAMP_STEP}) :
                  $signed({2'b00, pulse_r}) + $signed({{(PW_W-2){1'b0}}, RAMP_STEP});
    elapsed     = now_r - dstamp_r;
    if (ramp_pw > $signed({2'b00, max_r})) begin
      ramp_pw = $signed({2'b00, max_r});
    end
    if (ramp_pw < $signed({2'b00, min_r})) begin
      ramp_pw = $signed({2'b00, min_r});
    end
    if (op_r == OP_TOGGLE) begin
      running_nxt = ~running_r;
      if (!running_r) begin
        phase_nxt  = PH_START;
        asc_nxt    = 1'b1;
        target_nxt = '0;
      end else begin
        phase_nxt = PH_STOPPED;
      end
    end else begin
      phase_nxt = ph;
      case (ph)
        PH_START: begin
          target_nxt = '0;
          asc_nxt    = 1'b1;
          phase_nxt  = PH_COMPUTE;
        end
        PH_COMPUTE: begin
          if (asc_r) begin
            if (sum >= {1'b0, PCT_TOP}) begin
              target_nxt = PCT_TOP;
              asc_nxt    = 1'b0;
            end else begin
              target_nxt = sum[PCT_W-1:0];
            end
          end else begin
            target_nxt = (target_r <= step_r) ? '0 : PCT_W'(target_r - step_r);
          end
          goal_pend = 1'b1;
          ramp_nxt  = now_r;
          phase_nxt = PH_RAMP;
        end
        PH_RAMP: begin
          if (now_r != ramp_r) begin
            ramp_nxt  = now_r;
            wrote_nxt = 1'b1;
            if (ramp_mag > (PW_W+2)'(SNAP_BAND)) begin
              pulse_nxt = ramp_pw[PW_W-1:0];
            end else begin
              pulse_nxt  = goal_r;
              dstamp_nxt = now_r;
              phase_nxt  = PH_DWELL;
            end
          end
        end
        PH_DWELL: begin
          if (elapsed >= TIME_BITS'(dwell_r)) begin
            if (target_r == '0 && !asc_r) begin
              running_nxt = 1'b0;
              phase_nxt   = PH_STOPPED;
            end else begin
              phase_nxt = PH_COMPUTE;
            end
          end
        end
        default: begin
          running_nxt = 1'b0;
          target_nxt  = '0;
          asc_nxt     = 1'b1;
          if (pulse_r != min_r) begin
            pulse_nxt = min_r;
            wrote_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // operands for the goal map and the throttle map
  always_comb begin
    rng        = $signed({1'b0, max_r}) - $signed({1'b0, min_r});
    rng_abs    = rng[PW_W] ? PW_W'(-rng) : rng[PW_W-1:0];
    pdiff      = $signed({1'b0, pulse_r}) - $signed({1'b0, min_r});
    pdiff_abs  = pdiff[PW_W] ? PW_W'(-pdiff) : pdiff[PW_W-1:0];
    goal_prod  = DIV_NUM_W'(target_r) * DIV_NUM_W'(rng_abs);
    thr_prod   = DIV_NUM_W'(pdiff_abs) * DIV_NUM_W'(PCT_TOP);
    div_num    = thr_prod;
    div_den    = DIV_DEN_W'(rng_abs);
    goal_sh    = goal_prod_r[DIV_NUM_W-1:PCT_TOP_SH];
    goal_recip = GOAL_RCP_W'(goal_sh) * GOAL_RCP_W'(DIV5_MUL);
    goal_quo   = goal_recip[DIV5_SH +: PW_W];
    goal_val   = rng[PW_W] ?
                 $signed({2'b00, min_r}) - $signed({2'b00, goal_quo}) :
                 $signed({2'b00, min_r}) + $signed({2'b00, goal_quo});
    goal_nxt   = goal_val[PW_W-1:0];
    if (rng == '0) begin
      thr_nxt = '0;
    end else if ((pdiff[PW_W] != rng[PW_W]) && (pdiff != '0)) begin
      thr_nxt = '0;
    end else if (div_quo > DIV_NUM_W'(PCT_TOP)) begin
      thr_nxt = PCT_TOP;
    end else begin
      thr_nxt = div_quo[PCT_W-1:0];
    end
  end

  sts_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STOPPED;
      running_r <= 1'b0;
      asc_r     <= 1'b1;
      target_r  <= '0;
      pulse_r   <= PWM_MIN_RST;
      goal_r    <= PWM_MIN_RST;
      ramp_r    <= '0;
      dstamp_r  <= '0;
      wrote_r   <= 1'b0;
    end else begin
      if (cmd.update) begin
        phase_r   <= phase_nxt;
        running_r <= running_nxt;
        asc_r     <= asc_nxt;
        target_r  <= target_nxt;
        pulse_r   <= pulse_nxt;
        ramp_r    <= ramp_nxt;
        dstamp_r  <= dstamp_nxt;
        wrote_r   <= wrote_nxt;
      end
      if (cmd.goal_wr) begin
        goal_r <= goal_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.goal_mul) begin
      goal_prod_r <= goal_prod;
    end
    if (cmd.thr_wr) begin
      thr_r <= thr_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.pulse_width_us   <= pulse_r;
      out_data_r.throttle_percent <= thr_r;
      out_data_r.setpoint_percent <= target_r;
      out_data_r.active           <= running_r;
      out_data_r.phase            <= phase_r;
      out_data_r.pulse_write      <= wrote_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.goal_pend = goal_pend;
  assign status.div_done  = div_done;
  assign status.out_busy  = out_valid_r && !out_ready;

endmodule
`default_nettype wire

// ----- design/esc_staircase_throttle_sequencer.sv -----
// top level of the ESC staircase throttle sequencer
// depends on sts_pkg, sts_ctrl and sts_dp
//
// One item is taken at a time. An item runs from accept to result beat through
// the update, the setpoint map when it computes a new staircase step, and the
// radix-2 divider, which does the mapping of the pulse back to a throttle
// percent. The mapping of the setpoint onto the pulse range is a registered
// product and a reciprocal multiply. The result beat sits in an output
// register; a stalled result holds the next item in its final state only.
// Configuration writes are taken in any cycle and must land while idle.
`default_nettype none
module esc_staircase_throttle_sequencer #(
  parameter int TIME_BITS = sts_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sts_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sts_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sts_pkg::*;

  cmd_t    cmd;
  status_t status;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sts_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

// ----- tb/sts_sequence_checker.sv -----
// staircase sequencer checker: watches the input, result and register write channels,
// predicts each result beat from its own copy of the sequencer state and compares
// depends on sts_pkg
module sts_sequence_checker
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    fail_count
);

  logic [PW_W-1:0]    cfg_min;
  logic [PW_W-1:0]    cfg_max;
  logic [STEP_W-1:0]  cfg_step;
  logic [DWELL_W-1:0] cfg_dwell;

  phase_t             ph;
  logic               run_on;
  logic               going_up;
  int                 target_pct;
  int                 pulse_cur;
  int                 pulse_tgt;
  logic [NOW_W-1:0]   ramp_t;
  logic [NOW_W-1:0]   dwell_t;

  out_item_t          pulse_reports_q[$];
  int                 errors = 0;

  function automatic int pct_to_pulse(int p);
    int lo;
    int hi;
    int q;
    lo = int'(cfg_min);
    hi = int'(cfg_max);
    q  = p;
    if (q < 0) q = 0;
    if (q > int'(PCT_TOP)) q = int'(PCT_TOP);
    return (q * (hi - lo)) / int'(PCT_TOP) + lo;
  endfunction

  function automatic int pulse_to_pct(int pw);
    int lo;
    int hi;
    int r;
    lo = int'(cfg_min);
    hi = int'(cfg_max);
    if (hi == lo) return 0;
    r = ((pw - lo) * int'(PCT_TOP)) / (hi - lo);
    if (r < 0) r = 0;
    if (r > int'(PCT_TOP)) r = int'(PCT_TOP);
    return r;
  endfunction

  task automatic advance_staircase(input in_item_t it, output out_item_t res);
    logic             wrote;
    logic [NOW_W-1:0] el;
    int               diff;
    int               mag;
    int               tp;
    wrote = 1'b0;
    if (it.operation == OP_TOGGLE) begin
      run_on = !run_on;
      if (run_on) begin
        ph         = PH_START;
        going_up   = 1'b1;
        target_pct = 0;
      end else begin
        ph = PH_STOPPED;
      end
    end else begin
      if (!run_on) ph = PH_STOPPED;
      case (ph)
        PH_START: begin
          target_pct = 0;
          going_up   = 1'b1;
          ph         = PH_COMPUTE;
        end
        PH_COMPUTE: begin
          if (going_up) begin
            target_pct = target_pct + int'(cfg_step);
            if (target_pct >= int'(PCT_TOP)) begin
              target_pct = int'(PCT_TOP);
              going_up   = 1'b0;
            end
          end else begin
            target_pct = target_pct - int'(cfg_step);
            if (target_pct <= 0) target_pct = 0;
          end
          pulse_tgt = pct_to_pulse(target_pct);
          ramp_t    = it.now_ms;
          ph        = PH_RAMP;
        end
        PH_RAMP: begin
          el = it.now_ms - ramp_t;
          if (el >= 1) begin
            diff   = pulse_tgt - pulse_cur;
            mag    = (diff < 0) ? -diff : diff;
            ramp_t = it.now_ms;
            if (mag > int'(SNAP_BAND)) begin
              pulse_cur = pulse_cur + ((diff > 0) ? int'(RAMP_STEP) : -int'(RAMP_STEP));
              if (pulse_cur > int'(cfg_max)) pulse_cur = int'(cfg_max);
              if (pulse_cur < int'(cfg_min)) pulse_cur = int'(cfg_min);
            end else begin
              pulse_cur = pulse_tgt;
              dwell_t   = it.now_ms;
              ph        = PH_DWELL;
            end
            wrote = 1'b1;
          end
        end
        PH_DWELL: begin
          el = it.now_ms - dwell_t;
          if (el >= {16'd0, cfg_dwell}) begin
            if (target_pct == 0 && !going_up) begin
              run_on = 1'b0;
              ph     = PH_STOPPED;
            end else begin
              ph = PH_COMPUTE;
            end
          end
        end
        default: begin
          run_on     = 1'b0;
          target_pct = 0;
          going_up   = 1'b1;
          if (pulse_cur != int'(cfg_min)) begin
            pulse_cur = int'(cfg_min);
            wrote     = 1'b1;
          end
        end
      endcase
    end
    tp = pulse_to_pct(pulse_cur);
    res.pulse_width_us   = pulse_cur[PW_W-1:0];
    res.throttle_percent = tp[PCT_W-1:0];
    res.setpoint_percent = target_pct[PCT_W-1:0];
    res.active           = run_on;
    res.phase            = ph;
    res.pulse_write      = wrote;
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (pulse_reports_q.size() == 0) begin
      $error("result beat with no prediction pending: %h", got);
      errors++;
    end else begin
      want = pulse_reports_q.pop_front();
      if (got.pulse_width_us !== want.pulse_width_us) begin
        $error("pulse_width_us expected %0d got %0d", want.pulse_width_us, got.pulse_width_us);
        errors++;
      end
      if (got.throttle_percent !== want.throttle_percent) begin
        $error("throttle_percent expected %0d got %0d",
               want.throttle_percent, got.throttle_percent);
        errors++;
      end
      if (got.setpoint_percent !== want.setpoint_percent) begin
        $error("setpoint_percent expected %0d got %0d",
               want.setpoint_percent, got.setpoint_percent);
        errors++;
      end
      if (got.active !== want.active) begin
        $error("active expected %0d got %0d", want.active, got.active);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase expected %0d got %0d", want.phase, got.phase);
        errors++;
      end
      if (got.pulse_write !== want.pulse_write) begin
        $error("pulse_write expected %0d got %0d", want.pulse_write, got.pulse_write);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t pred;
    if (!rst_n) begin
      cfg_min    = PWM_MIN_RST;
      cfg_max    = PWM_MAX_RST;
      cfg_step   = STEP_RST;
      cfg_dwell  = DWELL_RST;
      ph         = PH_STOPPED;
      run_on     = 1'b0;
      going_up   = 1'b1;
      target_pct = 0;
      pulse_cur  = int'(PWM_MIN_RST);
      pulse_tgt  = int'(PWM_MIN_RST);
      ramp_t     = '0;
      dwell_t    = '0;
      pulse_reports_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PWM_MIN: cfg_min   = cfg_data[PW_W-1:0];
          CFG_PWM_MAX: cfg_max   = cfg_data[PW_W-1:0];
          CFG_STEP:    cfg_step  = cfg_data[STEP_W-1:0];
          CFG_DWELL:   cfg_dwell = cfg_data[DWELL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_report(out_data);
      if (in_valid && in_ready) begin
        advance_staircase(in_data, pred);
        pulse_reports_q.push_back(pred);
      end
    end
    outstanding <= pulse_reports_q.size();
    fail_count  <= errors;
  end

endmodule

// ----- tb/esc_staircase_throttle_sequencer_tb.sv -----
// testbench top for the ESC staircase throttle sequencer: clock, reset, register
// profiles, directed and random input beats, result back-pressure and the verdict
// depends on sts_pkg, sts_sequence_checker and the sequencer RTL
module esc_staircase_throttle_sequencer_tb;
  import sts_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int NUM_PROFILES = 10;
  localparam int BEATS_PER_PROFILE = 85;

  typedef struct {
    logic [PW_W-1:0]    lo_us;
    logic [PW_W-1:0]    hi_us;
    logic [STEP_W-1:0]  step;
    logic [DWELL_W-1:0] dwell;
  } profile_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_CHOKED
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    outstanding;
  int                    fail_count;

  logic [NOW_W-1:0]      clock_ms = '0;
  int                    cur_dwell = 0;
  int                    burst_left = 0;
  rx_mode_t              rx_mode = RX_OPEN;
  int                    rx_left = 0;
  int                    idle_cycles = 0;

  always #5 clk = ~clk;

  esc_staircase_throttle_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sts_sequence_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("FAIL esc_staircase_throttle_sequencer");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [NOW_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data.operation <= op;
    in_data.now_ms    <= stamp;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 199);
    if (pick < 3) begin
      send_item(OP_TOGGLE, $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick >= 10) begin
        if (pick < 75)      clock_ms = clock_ms + $urandom_range(1, 3);
        else if (pick < 92) clock_ms = clock_ms + $urandom_range(0, cur_dwell + 2);
        else                clock_ms = clock_ms + $urandom;
      end
      send_item(OP_EVAL, clock_ms);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_profile(input profile_t p);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    write_reg(CFG_PWM_MIN, p.lo_us);
    write_reg(CFG_PWM_MAX, p.hi_us);
    write_reg(CFG_STEP, p.step);
    write_reg(CFG_DWELL, p.dwell);
    cfg_valid <= 1'b0;
    cur_dwell = p.dwell;
    burst_left = 0;
  endtask

  function automatic profile_t profile_for(int idx);
    profile_t p;
    int       lo;
    case (idx)
      0: p = '{12'd1000, 12'd1100, 7'd40, 16'd2};
      1: p = '{12'd500, 12'd560, 7'd80, 16'd0};
      2: p = '{12'd2440, 12'd2500, 7'd1, 16'd65535};
      3: p = '{12'd2499, 12'd2500, 7'd20, 16'd1};
      4: p = '{12'd500, 12'd2500, 7'd16, 16'd10};
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          lo = $urandom_range(500, 2499);
          p.lo_us = PW_W'(lo);
          p.hi_us = PW_W'($urandom_range(lo + 1, 2500));
        end else begin
          lo = $urandom_range(500, 2400);
          p.lo_us = PW_W'(lo);
          p.hi_us = PW_W'(lo + $urandom_range(1, 100));
        end
        p.step  = STEP_W'($urandom_range(1, 80));
        p.dwell = ($urandom_range(0, 1) == 0) ? DWELL_W'($urandom_range(0, 8)) :
                                                DWELL_W'($urandom_range(0, 65535));
      end
    endcase
    return p;
  endfunction

  initial begin
    int k;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset profile: stopped, start, first step, ramp timing and wrap, forced stop
    send_item(OP_EVAL, 32'h0000_0000);
    send_item(OP_TOGGLE, 32'hFFFF_FFFF);
    send_item(OP_EVAL, 32'd10);
    send_item(OP_EVAL, 32'd10);
    send_item(OP_EVAL, 32'd10);
    send_item(OP_EVAL, 32'd11);
    send_item(OP_EVAL, 32'd11);
    send_item(OP_EVAL, 32'hFFFF_FFFF);
    send_item(OP_EVAL, 32'h0000_0000);
    send_item(OP_TOGGLE, 32'h0000_0000);
    send_item(OP_EVAL, 32'h8000_0000);
    send_item(OP_EVAL, 32'h7FFF_FFFF);
    send_item(OP_TOGGLE, 32'h5555_5555);
    send_item(OP_EVAL, 32'hAAAA_AAAA);
    send_item(OP_EVAL, 32'hAAAA_AAAB);
    send_item(OP_EVAL, 32'hAAAA_AAAC);

    clock_ms = $urandom;
    for (k = 0; k < NUM_PROFILES; k++) begin
      load_profile(profile_for(k));
      send_item(OP_TOGGLE, $urandom);
      for (n = 0; n < BEATS_PER_PROFILE; n++) send_random();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS esc_staircase_throttle_sequencer");
    end else begin
      $display("FAIL esc_staircase_throttle_sequencer");
    end
    $finish;
  end

endmodule
